FILE: rtl/wave_equation_grid_step_core_assert.svh
// Assertion macros for the wave equation grid step core.
// Used by the top level only; no other dependencies.
`ifndef WAVE_EQUATION_GRID_STEP_CORE_ASSERT_SVH
`define WAVE_EQUATION_GRID_STEP_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WEGS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wegs: assertion failed");
`define WEGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wegs: assertion failed");
`else
`define WEGS_ASSERT_NOW(label, ante, cons)
`define WEGS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/wegs_pkg.sv
// Shared types, constants and saturation helper for the grid step core.
// No dependencies.
`timescale 1ns / 1ps
package wegs_pkg;

  localparam int GRID_SIZE = 64;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int CRD_W     = $clog2(GRID_SIZE + 1);
  localparam int ADDR_W    = 5;

  // register indexes
  localparam logic [2:0] REG_GAIN     = 3'd0;
  localparam logic [2:0] REG_DT       = 3'd1;
  localparam logic [2:0] REG_SRC_ACC  = 3'd2;
  localparam logic [2:0] REG_SRC_COL  = 3'd3;
  localparam logic [2:0] REG_SRC_ROW  = 3'd4;
  localparam logic [2:0] REG_SRC_STEP = 3'd5;
  localparam logic [2:0] REG_WALL_COL = 3'd6;

  localparam logic MODE_STEP = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [15:0] STEP_MAX = 16'hFFFF;

  typedef struct packed {
    logic signed [31:0] laplace_gain;
    logic [30:0]        time_step;
    logic signed [31:0] source_accel;
    logic [5:0]         source_column;
    logic [5:0]         source_row_base;
    logic [15:0]        source_steps;
    logic [5:0]         wall_column;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic sweep;
    logic cnt_clr;
    logic capture;
    logic read;
    logic count_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic sweep_last;
    logic pipe_busy;
    logic out_free;
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SWEEP, ST_DRAIN, ST_READ, ST_RESP
  } state_t;

  // clamp a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/wegs_cfg.sv
// APB register file for the grid step core.
// Depends on wegs_pkg.
`timescale 1ns / 1ps
module wegs_cfg import wegs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.laplace_gain    <= 32'sd65536;
      cfg.time_step       <= 31'd6554;
      cfg.source_accel    <= 32'sd2621440;
      cfg.source_column   <= 6'd20;
      cfg.source_row_base <= 6'd15;
      cfg.source_steps    <= 16'd20;
      cfg.wall_column     <= 6'd54;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN:     cfg.laplace_gain    <= pwdata;
        REG_DT:       cfg.time_step       <= pwdata[30:0];
        REG_SRC_ACC:  cfg.source_accel    <= pwdata;
        REG_SRC_COL:  cfg.source_column   <= pwdata[5:0];
        REG_SRC_ROW:  cfg.source_row_base <= pwdata[5:0];
        REG_SRC_STEP: cfg.source_steps    <= pwdata[15:0];
        REG_WALL_COL: cfg.wall_column     <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_GAIN:     prdata = cfg.laplace_gain;
      REG_DT:       prdata = {1'b0, cfg.time_step};
      REG_SRC_ACC:  prdata = cfg.source_accel;
      REG_SRC_COL:  prdata = {26'd0, cfg.source_column};
      REG_SRC_ROW:  prdata = {26'd0, cfg.source_row_base};
      REG_SRC_STEP: prdata = {16'd0, cfg.source_steps};
      REG_WALL_COL: prdata = {26'd0, cfg.wall_column};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/wegs_ctrl.sv
// Sequencer for clearing, step sweeps and cell reads.
// Depends on wegs_pkg.
`timescale 1ns / 1ps
module wegs_ctrl import wegs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  mode,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (mode == MODE_STEP) ? ST_SWEEP : ST_READ;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.count_step = 1'b1;
          state_next     = ST_RESP;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

FILE: rtl/wegs_datapath.sv
// Grid memories, line buffer, update pipeline and result register.
// Depends on wegs_pkg.
`timescale 1ns / 1ps
module wegs_datapath import wegs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               mode,
  input  logic [5:0]         col,
  input  logic [5:0]         row,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [31:0] displacement,
  output logic signed [31:0] velocity,
  output logic signed [31:0] acceleration,
  output logic [15:0]        step_count
);

  typedef struct packed {
    logic [CRD_W-1:0]   row;
    logic [CRD_W-1:0]   col;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } cell_t;

  logic signed [31:0] disp_mem [CELLS];
  logic signed [31:0] vel_mem  [CELLS];
  logic signed [31:0] acc_mem  [CELLS];

  logic [IDX_W:0]     cnt;
  logic [CRD_W-1:0]   cnt_col, cnt_row;
  logic [15:0]        steps;
  logic               mode_q;
  logic [5:0]         col_q, row_q;
  logic [IDX_W-1:0]   rd_addr, disp_raddr, vel_raddr, waddr, cidx_a;
  logic               rd_grid, disp_en, vel_en, we;
  logic signed [31:0] disp_q, vel_q, acc_q;
  logic signed [31:0] line [2*GRID_SIZE+1];

  logic               b_valid, b_zero, b_ctr;
  logic [CRD_W-1:0]   b_row, b_col;
  logic [IDX_W-1:0]   b_idx;
  logic               c_valid, d_valid, e_valid, f_valid, g_valid, h_valid, w_valid;
  cell_t              c_cell, d_cell, e_cell, f_cell, g_cell, h_cell, w_cell;
  logic signed [31:0] d_lap, f_acc, g_acc, h_acc, h_vel, w_acc;
  logic signed [63:0] e_prod, g_prod, w_prod;
  logic signed [31:0] lap_sat, acc_new, vel_new, disp_new, wdata_d, wdata_v, wdata_a;
  logic signed [63:0] lt, rt, up, dn, lap_sum, a_sum, v_sum, u_sum;
  logic [16:0]        src_first, src_row;
  logic               src_hit, wall_hit;

  // sweep and clear counters
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      cnt     <= '0;
      cnt_col <= '0;
      cnt_row <= '0;
    end else if (cmd.clear || cmd.sweep) begin
      cnt <= cnt + 1'b1;
      if (cnt_col == CRD_W'(GRID_SIZE - 1)) begin
        cnt_col <= '0;
        cnt_row <= cnt_row + 1'b1;
      end else begin
        cnt_col <= cnt_col + 1'b1;
      end
    end
  end

  assign stat.clear_last = (cnt == (IDX_W+1)'(CELLS - 1));
  assign stat.sweep_last = (cnt_row == CRD_W'(GRID_SIZE)) &&
                           (cnt_col == CRD_W'(GRID_SIZE - 1));
  assign stat.pipe_busy  = b_valid | c_valid | d_valid | e_valid | f_valid |
                           g_valid | h_valid | w_valid;
  assign stat.out_free   = !out_valid || !out_stall;

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      col_q  <= col;
      row_q  <= row;
    end
  end

  assign rd_grid = (32'(row_q) < GRID_SIZE) && (32'(col_q) < GRID_SIZE);
  assign rd_addr = IDX_W'(32'(row_q) * GRID_SIZE + 32'(col_q));
  assign cidx_a  = IDX_W'(cnt - (IDX_W+1)'(GRID_SIZE));

  // memory ports
  always_comb begin
    disp_en    = (cmd.sweep && cnt_row != CRD_W'(GRID_SIZE)) || cmd.read;
    vel_en     = cmd.sweep || cmd.read;
    disp_raddr = cmd.sweep ? cnt[IDX_W-1:0] : rd_addr;
    vel_raddr  = cmd.sweep ? cidx_a : rd_addr;
    we         = cmd.clear || (w_valid && !wall_hit);
    waddr      = cmd.clear ? cnt[IDX_W-1:0] : w_cell.idx;
    wdata_d    = cmd.clear ? 32'sd0 : disp_new;
    wdata_v    = cmd.clear ? 32'sd0 : w_cell.v;
    wdata_a    = cmd.clear ? 32'sd0 : w_acc;
  end

  always_ff @(posedge clk) begin
    if (disp_en)  disp_q <= disp_mem[disp_raddr];
    if (we)       disp_mem[waddr] <= wdata_d;
  end

  always_ff @(posedge clk) begin
    if (vel_en)   vel_q <= vel_mem[vel_raddr];
    if (we)       vel_mem[waddr] <= wdata_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.read) acc_q <= acc_mem[rd_addr];
    if (we)       acc_mem[waddr] <= wdata_a;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
      h_valid <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      b_valid <= cmd.sweep;
      c_valid <= b_valid && b_ctr;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
      h_valid <= g_valid;
      w_valid <= h_valid;
    end
  end

  // stage B: tag the fetched word
  always_ff @(posedge clk) begin
    b_zero <= (cnt_row == CRD_W'(GRID_SIZE));
    b_ctr  <= (cnt_row != '0);
    b_row  <= cnt_row - 1'b1;
    b_col  <= cnt_col;
    b_idx  <= cidx_a;
  end

  // shift the line buffer: newest word at tap zero, centre at the middle
  always_ff @(posedge clk) begin
    if (b_valid) begin
      line[0] <= b_zero ? 32'sd0 : disp_q;
      for (int i = 1; i <= 2*GRID_SIZE; i++) line[i] <= line[i-1];
    end
  end

  always_ff @(posedge clk) begin
    c_cell.row <= b_row;
    c_cell.col <= b_col;
    c_cell.idx <= b_idx;
    c_cell.u   <= '0;
    c_cell.v   <= vel_q;
  end

  // stage C: five-point Laplacian, out-of-grid neighbours as zero
  always_comb begin
    lt = (c_cell.col == '0) ? 64'sd0 : 64'(line[GRID_SIZE+1]);
    rt = (c_cell.col == CRD_W'(GRID_SIZE - 1)) ? 64'sd0 : 64'(line[GRID_SIZE-1]);
    up = (c_cell.row == '0) ? 64'sd0 : 64'(line[2*GRID_SIZE]);
    dn = (c_cell.row == CRD_W'(GRID_SIZE - 1)) ? 64'sd0 : 64'(line[0]);
    lap_sum = lt + rt + up + dn - (64'(line[GRID_SIZE]) <<< 2);
    lap_sat = sat32(lap_sum);
  end

  always_ff @(posedge clk) begin
    d_lap  <= lap_sat;
    d_cell <= {c_cell.row, c_cell.col, c_cell.idx, line[GRID_SIZE], c_cell.v};
  end

  // stage D: gain multiply
  always_ff @(posedge clk) begin
    e_prod <= 64'(d_lap) * 64'(cfg.laplace_gain);
    e_cell <= d_cell;
  end

  // stage E: scale, add drive on the source segment
  always_comb begin
    src_first = 17'(cfg.source_row_base) + 17'(steps);
    src_row   = 17'(e_cell.row);
    src_hit   = (steps < cfg.source_steps) &&
                (32'(e_cell.col) == 32'(cfg.source_column)) &&
                (src_row >= src_first) && (src_row <= src_first + 17'd2);
    a_sum     = (e_prod >>> 16) + (src_hit ? 64'(cfg.source_accel) : 64'sd0);
    acc_new   = sat32(a_sum);
  end

  always_ff @(posedge clk) begin
    f_acc  <= acc_new;
    f_cell <= e_cell;
  end

  // stage F: acceleration times time step
  always_ff @(posedge clk) begin
    g_prod <= 64'(f_acc) * 64'($signed({1'b0, cfg.time_step}));
    g_acc  <= f_acc;
    g_cell <= f_cell;
  end

  // stage G: new velocity
  always_comb begin
    v_sum   = 64'(g_cell.v) + (g_prod >>> 16);
    vel_new = sat32(v_sum);
  end

  always_ff @(posedge clk) begin
    h_vel  <= vel_new;
    h_acc  <= g_acc;
    h_cell <= g_cell;
  end

  // stage H: velocity times time step
  always_ff @(posedge clk) begin
    w_prod <= 64'(h_vel) * 64'($signed({1'b0, cfg.time_step}));
    w_acc  <= h_acc;
    w_cell <= {h_cell.row, h_cell.col, h_cell.idx, h_cell.u, h_vel};
  end

  // write stage: new displacement, skip the wall column
  always_comb begin
    u_sum    = 64'(w_cell.u) + (w_prod >>> 16);
    disp_new = sat32(u_sum);
    wall_hit = (32'(w_cell.col) == 32'(cfg.wall_column));
  end

  // step counter, saturating
  always_ff @(posedge clk) begin
    if (rst) steps <= '0;
    else if (cmd.count_step && steps != STEP_MAX) steps <= steps + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      step_count <= steps;
      if (mode_q == MODE_READ && rd_grid) begin
        displacement <= disp_q;
        velocity     <= vel_q;
        acceleration <= acc_q;
      end else begin
        displacement <= '0;
        velocity     <= '0;
        acceleration <= '0;
      end
    end
  end

endmodule

FILE: rtl/wave_equation_grid_step_core.sv
// Step request: one sweep of GRID_SIZE+1 rows, one cell a cycle through the single
// displacement read port; the result is loaded once the update pipeline has drained
// and the result register is free. Read request: the cell is read, then its result
// is loaded. No further request is taken before the result is loaded, but a new
// request is taken while the result waits. After reset a clearing pass zeroes every
// cell of the grids; requests are held off until it ends, register writes are not.
`timescale 1ns / 1ps
`include "wave_equation_grid_step_core_assert.svh"
module wave_equation_grid_step_core import wegs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [5:0]         col,
  input  logic [5:0]         row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] displacement,
  output logic signed [31:0] velocity,
  output logic signed [31:0] acceleration,
  output logic [15:0]        step_count
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  wegs_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  wegs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .mode, .in_stall, .stat, .cmd
  );

  wegs_datapath u_dp (
    .clk, .rst, .cfg, .cmd, .stat, .mode, .col, .row, .out_stall, .out_valid,
    .displacement, .velocity, .acceleration, .step_count
  );

  // hold off further requests once one is taken
  `WEGS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // never overwrite a result still waiting
  `WEGS_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid || !out_stall)
  // count the step only once the pipeline is empty
  `WEGS_ASSERT_NOW(a_count_drained, cmd.count_step, !stat.pipe_busy)

endmodule
